/* sv/spid_pkg.sv */
// types, constants and saturation helpers shared by the self-tuning pid controller
// no dependencies

package spid_pkg;

    localparam int GAIN_W  = 32;
    localparam int STEER_W = 48;
    localparam int INTEG_W = 48;
    localparam int ABS_W   = 32;
    localparam int SQ_W    = 48;
    localparam int CNT_W   = 16;
    localparam int LR_W    = 32;
    localparam int RMS_W   = 24;
    localparam int THR_W   = 24;
    localparam int WIDE_W  = 64;
    localparam int LEN_W   = 17;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam int MUL_STEPS  = 64;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_CNT_W = 6;

    // register indexes
    localparam logic [IDX_W-1:0] REG_KP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI  = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEN = 3'd4;
    localparam logic [IDX_W-1:0] REG_THR = 3'd5;

    localparam logic [CNT_W-1:0] LEN_RESET = 16'd100;

    // rate scale by 1/25600 (100 in q16.8): 25600 = 25 * 2^10, 2^23 = 25 * 335544 + 8
    localparam logic [18:0] LR_HI_MULT = 19'd335544;
    // ceil(2^32 / 25), exact for numerators below 2^27
    localparam logic [27:0] LR_RECIP   = 28'd171798692;

    localparam logic [WIDE_W-1:0] PROD_LIM = 64'h2000_0000_0000_0000;
    localparam logic [WIDE_W-1:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

    // datapath actions, one per cycle
    localparam int ACT_W = 5;
    localparam logic [ACT_W-1:0] ACT_NONE      = 5'd0;
    localparam logic [ACT_W-1:0] ACT_ACCEPT    = 5'd1;
    localparam logic [ACT_W-1:0] ACT_SQ        = 5'd2;
    localparam logic [ACT_W-1:0] ACT_PD        = 5'd3;
    localparam logic [ACT_W-1:0] ACT_MUL_INTEG = 5'd4;
    localparam logic [ACT_W-1:0] ACT_STEER     = 5'd5;
    localparam logic [ACT_W-1:0] ACT_DIV_MS    = 5'd6;
    localparam logic [ACT_W-1:0] ACT_SQRT      = 5'd7;
    localparam logic [ACT_W-1:0] ACT_RMS       = 5'd8;
    localparam logic [ACT_W-1:0] ACT_DIV_LR    = 5'd9;
    localparam logic [ACT_W-1:0] ACT_LR        = 5'd10;
    localparam logic [ACT_W-1:0] ACT_T1        = 5'd11;
    localparam logic [ACT_W-1:0] ACT_T2        = 5'd12;
    localparam logic [ACT_W-1:0] ACT_T3        = 5'd13;
    localparam logic [ACT_W-1:0] ACT_GAIN      = 5'd14;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 5'd15;
    localparam logic [ACT_W-1:0] ACT_PUBLISH   = 5'd16;

    // gain select
    localparam logic [1:0] GSEL_KP = 2'd0;
    localparam logic [1:0] GSEL_KI = 2'd1;
    localparam logic [1:0] GSEL_KD = 2'd2;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       idx;
        logic [DATA_W-1:0]      data;
    } cfg_wr_t;

    typedef struct packed {
        logic [ACT_W-1:0]       act;
        logic [1:0]             gsel;
    } dp_cmd_t;

    typedef struct packed {
        logic                   mul_done;
        logic                   dsq_done;
        logic                   epoch_hit;
        logic                   training;
        logic                   out_free;
    } dp_stat_t;

    function automatic logic signed [WIDE_W-1:0] sat61(input logic signed [65:0] x);
        logic signed [65:0] lim;
        lim = $signed({2'b00, PROD_LIM});
        if (x > lim)
            return $signed(PROD_LIM);
        else if (x < -lim)
            return -$signed(PROD_LIM);
        else
            return x[WIDE_W-1:0];
    endfunction

    function automatic logic signed [STEER_W-1:0] sat48(input logic signed [WIDE_W-1:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        else if (x < -64'sh0000_8000_0000_0000)
            return 48'sh8000_0000_0000;
        else
            return x[STEER_W-1:0];
    endfunction

    function automatic logic signed [GAIN_W-1:0] sat32(input logic signed [WIDE_W:0] x);
        if (x > 65'sh0_0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -65'sh0_0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return x[GAIN_W-1:0];
    endfunction

endpackage

/* sv/self_tuning_pid_controller.sv */
// top level of the self-tuning pid controller: register port, controller and datapath
// depends on spid_pkg, spid_ctrl, spid_dpath

// One signed error sample per transaction gives one result transaction: steer, the
// saturated q32.16 pid drive (kp*e + kd*(e - last e) + ki*running sum, with the sum
// already holding e, using the gains held before this sample's tuning), and
// still_training. An ordinary sample's result waits on the serial multiplier that forms
// ki times the 48-bit running sum one bit a cycle. A sample that closes an epoch while
// tuning is on goes on to a 64-step divide for the mean square, a 32-step square root, a
// 64-step multiply and a reciprocal scaling for the learning-rate decay, and three gain
// updates of three 64-step multiplies each, all on one shared multiplier and one
// divide/root unit; when that epoch ends tuning, the gain updates are skipped. A new
// sample is taken once the previous one has reached the output register, which holds it
// until taken. Registers sit at byte addresses 4*i (kp_init, ki_init, kd_init,
// learn_rate_init, epoch_length, error_threshold); writing a gain or the rate also loads
// the working value, and writes belong to idle periods only.

module self_tuning_pid_controller #(
    parameter int ERROR_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [spid_pkg::ADDR_W-1:0]           paddr,
    input  logic [spid_pkg::DATA_W-1:0]           pwdata,
    output logic [spid_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    // sample channel
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [ERROR_BITS-1:0]          error_sample,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [spid_pkg::STEER_W-1:0]   steer,
    output logic                                  still_training
);

    logic [spid_pkg::DATA_W-1:0]  kp_init_reg;
    logic [spid_pkg::DATA_W-1:0]  ki_init_reg;
    logic [spid_pkg::DATA_W-1:0]  kd_init_reg;
    logic [spid_pkg::LR_W-1:0]    lr_init_reg;
    logic [spid_pkg::CNT_W-1:0]   len_reg;
    logic [spid_pkg::THR_W-1:0]   thr_reg;

    spid_pkg::cfg_wr_t            cfg_wr;
    spid_pkg::dp_cmd_t            cmd;
    spid_pkg::dp_stat_t           stat;
    logic [spid_pkg::IDX_W-1:0]   reg_idx;

    // word address selects the register
    assign reg_idx     = paddr[spid_pkg::ADDR_W-1:2];
    assign pready      = 1'b1;
    assign cfg_wr.we   = psel && penable && pwrite;
    assign cfg_wr.idx  = reg_idx;
    assign cfg_wr.data = pwdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_init_reg <= '0;
            ki_init_reg <= '0;
            kd_init_reg <= '0;
            lr_init_reg <= '0;
            len_reg     <= spid_pkg::LEN_RESET;
            thr_reg     <= '0;
        end
        else if (cfg_wr.we)
        begin
            case (reg_idx)
                spid_pkg::REG_KP:  kp_init_reg <= pwdata;
                spid_pkg::REG_KI:  ki_init_reg <= pwdata;
                spid_pkg::REG_KD:  kd_init_reg <= pwdata;
                spid_pkg::REG_LR:  lr_init_reg <= pwdata;
                spid_pkg::REG_LEN: len_reg     <= pwdata[spid_pkg::CNT_W-1:0];
                spid_pkg::REG_THR: thr_reg     <= pwdata[spid_pkg::THR_W-1:0];
                default:           thr_reg     <= thr_reg;
            endcase
        end
    end

    // read-back of the programmed values
    always_comb
    begin
        case (reg_idx)
            spid_pkg::REG_KP:  prdata = kp_init_reg;
            spid_pkg::REG_KI:  prdata = ki_init_reg;
            spid_pkg::REG_KD:  prdata = kd_init_reg;
            spid_pkg::REG_LR:  prdata = lr_init_reg;
            spid_pkg::REG_LEN: prdata = {16'b0, len_reg};
            spid_pkg::REG_THR: prdata = {8'b0, thr_reg};
            default:           prdata = '0;
        endcase
    end

    spid_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    spid_dpath #(
        .ERROR_BITS (ERROR_BITS)
    ) u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr          (cfg_wr),
        .epoch_length    (len_reg),
        .error_threshold (thr_reg),
        .error_sample    (error_sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .steer           (steer),
        .still_training  (still_training)
    );

endmodule

/* sv/spid_mul.sv */
// serial saturating multiplier, one bit of the second operand per cycle
// depends on spid_pkg

module spid_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [spid_pkg::WIDE_W-1:0]   op_a,
    input  logic signed [spid_pkg::WIDE_W-1:0]   op_b,
    output logic                                 done,
    output logic signed [spid_pkg::WIDE_W-1:0]   product
);

    logic [spid_pkg::WIDE_W-1:0]      ua_reg;
    logic [spid_pkg::WIDE_W-1:0]      ub_reg;
    logic [spid_pkg::WIDE_W-1:0]      acc_reg;
    logic                             neg_reg;
    logic [spid_pkg::STEP_CNT_W-1:0]  cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [spid_pkg::WIDE_W:0]        sum_next;
    logic [spid_pkg::WIDE_W-1:0]      acc_next;

    // msb first: acc = 2*acc + (bit ? a : 0), clamped at the limit
    always_comb
    begin
        sum_next = {1'b0, acc_reg[spid_pkg::WIDE_W-2:0], 1'b0}
                 + {1'b0, (ub_reg[spid_pkg::WIDE_W-1] ? ua_reg : '0)};
        if (sum_next > {1'b0, spid_pkg::PROD_LIM})
            acc_next = spid_pkg::PROD_LIM;
        else
            acc_next = sum_next[spid_pkg::WIDE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= spid_pkg::STEP_CNT_W'(spid_pkg::MUL_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= op_a[spid_pkg::WIDE_W-1] ? 64'(-op_a) : 64'(op_a);
            ub_reg  <= op_b[spid_pkg::WIDE_W-1] ? 64'(-op_b) : 64'(op_b);
            neg_reg <= op_a[spid_pkg::WIDE_W-1] ^ op_b[spid_pkg::WIDE_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            ub_reg  <= {ub_reg[spid_pkg::WIDE_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

/* sv/spid_dsq.sv */
// shared serial unit: restoring divide by a narrow divisor, or integer square root
// depends on spid_pkg

module spid_dsq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              sqrt_mode,
    input  logic [spid_pkg::WIDE_W-1:0]       dividend,
    input  logic [spid_pkg::LEN_W-1:0]        divisor,
    output logic                              done,
    output logic [spid_pkg::WIDE_W-1:0]       result
);

    logic [spid_pkg::WIDE_W-1:0]      a_reg;
    logic [spid_pkg::WIDE_W-1:0]      q_reg;
    logic [spid_pkg::WIDE_W-1:0]      bit_reg;
    logic [spid_pkg::LEN_W-1:0]       r_reg;
    logic [spid_pkg::LEN_W-1:0]       div_reg;
    logic                             sqrt_reg;
    logic [spid_pkg::STEP_CNT_W-1:0]  cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [spid_pkg::LEN_W:0]         rs_next;
    logic [spid_pkg::LEN_W:0]         rd_next;
    logic [spid_pkg::WIDE_W-1:0]      trial_next;

    always_comb
    begin
        rs_next    = {r_reg, a_reg[spid_pkg::WIDE_W-1]};
        rd_next    = rs_next - {1'b0, div_reg};
        trial_next = q_reg + bit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= sqrt_mode ? spid_pkg::STEP_CNT_W'(spid_pkg::SQRT_STEPS - 1)
                                  : spid_pkg::STEP_CNT_W'(spid_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= dividend;
            q_reg    <= '0;
            bit_reg  <= spid_pkg::SQRT_TOP_BIT;
            r_reg    <= '0;
            div_reg  <= divisor;
            sqrt_reg <= sqrt_mode;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                if (a_reg >= trial_next)
                begin
                    a_reg <= a_reg - trial_next;
                    q_reg <= (q_reg >> 1) + bit_reg;
                end
                else
                begin
                    q_reg <= q_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                // quotient bits shift into the dividend register
                if (rs_next >= {1'b0, div_reg})
                begin
                    r_reg <= rd_next[spid_pkg::LEN_W-1:0];
                    a_reg <= {a_reg[spid_pkg::WIDE_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= rs_next[spid_pkg::LEN_W-1:0];
                    a_reg <= {a_reg[spid_pkg::WIDE_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = sqrt_reg ? q_reg : a_reg;

endmodule

/* sv/spid_dpath.sv */
// datapath: controller state, epoch sums, gain tuning arithmetic and output register
// depends on spid_pkg, spid_mul, spid_dsq

module spid_dpath #(
    parameter int ERROR_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spid_pkg::dp_cmd_t                     cmd,
    output spid_pkg::dp_stat_t                    stat,
    input  spid_pkg::cfg_wr_t                     cfg_wr,
    input  logic [spid_pkg::CNT_W-1:0]            epoch_length,
    input  logic [spid_pkg::THR_W-1:0]            error_threshold,
    input  logic signed [ERROR_BITS-1:0]          error_sample,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [spid_pkg::STEER_W-1:0]   steer,
    output logic                                  still_training
);

    localparam int SQSUM_W = ((2 * ERROR_BITS > spid_pkg::SQ_W) ? 2 * ERROR_BITS
                                                               : spid_pkg::SQ_W) + 1;
    localparam int PP_W = spid_pkg::GAIN_W + ERROR_BITS;
    localparam int PD_W = spid_pkg::GAIN_W + ERROR_BITS + 1;

    // tuned state
    logic signed [spid_pkg::GAIN_W-1:0]   kp_reg, ki_reg, kd_reg;
    logic signed [ERROR_BITS-1:0]         last_reg;
    logic signed [spid_pkg::INTEG_W-1:0]  integ_reg;
    logic [spid_pkg::ABS_W-1:0]           abs_reg;
    logic [spid_pkg::SQ_W-1:0]            sq_reg;
    logic [spid_pkg::CNT_W-1:0]           cnt_reg;
    logic [spid_pkg::LR_W-1:0]            lr_reg;
    logic                                 train_reg;
    logic [spid_pkg::RMS_W-1:0]           prev_reg;
    logic                                 epoch_hit_reg;

    // per-item working registers
    logic signed [ERROR_BITS-1:0]         e_reg;
    logic signed [ERROR_BITS:0]           d_reg;
    logic [ERROR_BITS-1:0]                ae_reg;
    logic signed [spid_pkg::WIDE_W-1:0]   prod_p_reg, prod_d_reg;
    logic signed [spid_pkg::STEER_W-1:0]  steer_hold_reg;
    logic [spid_pkg::RMS_W-1:0]           rms_reg;
    logic signed [spid_pkg::RMS_W:0]      delta_reg;
    logic [26:0]                          lrz_reg;
    logic [41:0]                          lrhi_reg;

    // output register
    logic                                 valid_reg;
    logic signed [spid_pkg::STEER_W-1:0]  steer_reg;
    logic                                 still_reg;

    logic signed [ERROR_BITS:0]           d_next;
    logic [ERROR_BITS:0]                  e_neg;
    logic [ERROR_BITS-1:0]                ae_next;
    logic signed [spid_pkg::INTEG_W:0]    integ_sum;
    logic signed [spid_pkg::INTEG_W-1:0]  integ_next;
    logic [spid_pkg::ABS_W:0]             abs_sum;
    logic [spid_pkg::ABS_W-1:0]           abs_next;
    logic [2*ERROR_BITS-1:0]              ae_sq;
    logic [SQSUM_W-1:0]                   sq_sum;
    logic [spid_pkg::SQ_W-1:0]            sq_next;
    logic [spid_pkg::CNT_W-1:0]           cnt_inc;
    logic signed [PP_W-1:0]               pp;
    logic signed [PD_W-1:0]               pdd;
    logic [spid_pkg::LEN_W-1:0]           len;
    logic [spid_pkg::RMS_W-1:0]           rms_next;
    logic [45:0]                          lr_y;
    logic [26:0]                          lrz_next;
    logic [41:0]                          lrhi_next;
    logic [54:0]                          lr_prod;
    logic [41:0]                          lr_quot;
    logic [spid_pkg::LR_W-1:0]            lr_next;
    logic signed [spid_pkg::GAIN_W-1:0]   gain_sel;
    logic signed [spid_pkg::WIDE_W-1:0]   term_sel;
    logic signed [spid_pkg::GAIN_W-1:0]   gain_next;
    logic signed [spid_pkg::WIDE_W-1:0]   steer_sum;

    logic                                 mul_start;
    logic signed [spid_pkg::WIDE_W-1:0]   mul_a, mul_b, mul_p;
    logic                                 mul_done;
    logic                                 dsq_start, dsq_sqrt;
    logic [spid_pkg::WIDE_W-1:0]          dsq_dividend, dsq_res;
    logic [spid_pkg::LEN_W-1:0]           dsq_divisor;
    logic                                 dsq_done;

    // item arithmetic
    always_comb
    begin
        d_next    = (ERROR_BITS+1)'(error_sample) - (ERROR_BITS+1)'(last_reg);
        e_neg     = -((ERROR_BITS+1)'(error_sample));
        ae_next   = error_sample[ERROR_BITS-1] ? e_neg[ERROR_BITS-1:0] : error_sample;
        integ_sum = (spid_pkg::INTEG_W+1)'(integ_reg) + (spid_pkg::INTEG_W+1)'(error_sample);
        if (integ_sum[spid_pkg::INTEG_W] != integ_sum[spid_pkg::INTEG_W-1])
            integ_next = integ_sum[spid_pkg::INTEG_W] ? 48'sh8000_0000_0000
                                                     : 48'sh7FFF_FFFF_FFFF;
        else
            integ_next = integ_sum[spid_pkg::INTEG_W-1:0];
        abs_sum  = {1'b0, abs_reg} + (spid_pkg::ABS_W+1)'(ae_next);
        abs_next = abs_sum[spid_pkg::ABS_W] ? '1 : abs_sum[spid_pkg::ABS_W-1:0];
        ae_sq    = ae_reg * ae_reg;
        sq_sum   = SQSUM_W'(sq_reg) + SQSUM_W'(ae_sq);
        sq_next  = (sq_sum[SQSUM_W-1:spid_pkg::SQ_W] != '0) ? '1
                                                           : sq_sum[spid_pkg::SQ_W-1:0];
        cnt_inc  = cnt_reg + 1'b1;
        pp       = kp_reg * e_reg;
        pdd      = kd_reg * d_reg;
        steer_sum = prod_p_reg + prod_d_reg + mul_p;
    end

    // epoch end arithmetic
    always_comb
    begin
        len      = (epoch_length == '0) ? 17'h1_0000 : {1'b0, epoch_length};
        rms_next = (dsq_res[spid_pkg::WIDE_W-1:spid_pkg::RMS_W] != '0) ? '1
                                                               : dsq_res[spid_pkg::RMS_W-1:0];
        // rate * rms / 25600: drop 2^10, then split the divide by 25 across the lrz/lrhi registers
        lr_y      = mul_p[55:10];
        lrz_next  = {1'b0, lr_y[45:23], 3'b000} + {4'b0, lr_y[22:0]};
        lrhi_next = 42'(lr_y[45:23]) * 42'(spid_pkg::LR_HI_MULT);
        lr_prod   = 55'(lrz_reg) * 55'(spid_pkg::LR_RECIP);
        lr_quot   = lrhi_reg + 42'(lr_prod[54:32]);
        lr_next   = (lr_quot[41:32] != '0) ? '1 : lr_quot[31:0];
        case (cmd.gsel)
            spid_pkg::GSEL_KP:
            begin
                gain_sel = kp_reg;
                term_sel = 64'(e_reg);
            end
            spid_pkg::GSEL_KI:
            begin
                gain_sel = ki_reg;
                term_sel = $signed({32'b0, abs_reg});
            end
            default:
            begin
                gain_sel = kd_reg;
                term_sel = 64'(d_reg);
            end
        endcase
        gain_next = spid_pkg::sat32(65'(gain_sel) - 65'(mul_p >>> 24));
    end

    // unit operand selection
    always_comb
    begin
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        dsq_start    = 1'b0;
        dsq_sqrt     = 1'b0;
        dsq_dividend = '0;
        dsq_divisor  = len;
        case (cmd.act)
            spid_pkg::ACT_MUL_INTEG:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(ki_reg);
                mul_b     = 64'(integ_reg);
            end
            spid_pkg::ACT_RMS:
            begin
                mul_start = 1'b1;
                mul_a     = $signed({32'b0, lr_reg});
                mul_b     = $signed({40'b0, rms_next});
            end
            spid_pkg::ACT_T1:
            begin
                mul_start = 1'b1;
                mul_a     = 64'(gain_sel);
                mul_b     = term_sel;
            end
            spid_pkg::ACT_T2:
            begin
                mul_start = 1'b1;
                mul_a     = mul_p;
                mul_b     = 64'(delta_reg);
            end
            spid_pkg::ACT_T3:
            begin
                mul_start = 1'b1;
                mul_a     = mul_p >>> 8;
                mul_b     = $signed({32'b0, lr_reg});
            end
            spid_pkg::ACT_DIV_MS:
            begin
                dsq_start    = 1'b1;
                dsq_dividend = {sq_reg, 16'b0};
                dsq_divisor  = len;
            end
            spid_pkg::ACT_SQRT:
            begin
                dsq_start    = 1'b1;
                dsq_sqrt     = 1'b1;
                dsq_dividend = dsq_res;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    spid_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    spid_dsq u_dsq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dsq_start),
        .sqrt_mode (dsq_sqrt),
        .dividend  (dsq_dividend),
        .divisor   (dsq_divisor),
        .done      (dsq_done),
        .result    (dsq_res)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            last_reg      <= '0;
            integ_reg     <= '0;
            abs_reg       <= '0;
            sq_reg        <= '0;
            cnt_reg       <= '0;
            lr_reg        <= '0;
            train_reg     <= 1'b1;
            prev_reg      <= '0;
            epoch_hit_reg <= 1'b0;
        end
        else
        begin
            case (cmd.act)
                spid_pkg::ACT_ACCEPT:
                begin
                    last_reg  <= error_sample;
                    integ_reg <= integ_next;
                    abs_reg   <= abs_next;
                    if (cnt_inc == epoch_length)
                    begin
                        cnt_reg       <= '0;
                        epoch_hit_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg       <= cnt_inc;
                        epoch_hit_reg <= 1'b0;
                    end
                end
                spid_pkg::ACT_SQ:
                begin
                    sq_reg <= sq_next;
                end
                spid_pkg::ACT_LR:
                begin
                    lr_reg    <= lr_next;
                    train_reg <= (rms_reg > error_threshold);
                    if (rms_reg > error_threshold)
                        prev_reg <= rms_reg;
                end
                spid_pkg::ACT_GAIN:
                begin
                    case (cmd.gsel)
                        spid_pkg::GSEL_KP: kp_reg <= gain_next;
                        spid_pkg::GSEL_KI: ki_reg <= gain_next;
                        default:           kd_reg <= gain_next;
                    endcase
                end
                spid_pkg::ACT_CLEAR:
                begin
                    abs_reg <= '0;
                    sq_reg  <= '0;
                end
                default:
                begin
                    epoch_hit_reg <= epoch_hit_reg;
                end
            endcase
            // register writes load the working gains and rate
            if (cfg_wr.we)
            begin
                case (cfg_wr.idx)
                    spid_pkg::REG_KP: kp_reg <= $signed(cfg_wr.data);
                    spid_pkg::REG_KI: ki_reg <= $signed(cfg_wr.data);
                    spid_pkg::REG_KD: kd_reg <= $signed(cfg_wr.data);
                    spid_pkg::REG_LR: lr_reg <= cfg_wr.data;
                    default:          lr_reg <= lr_reg;
                endcase
            end
        end
    end

    // result valid: set on publish, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.act == spid_pkg::ACT_PUBLISH)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.act)
            spid_pkg::ACT_ACCEPT:
            begin
                e_reg  <= error_sample;
                d_reg  <= d_next;
                ae_reg <= ae_next;
            end
            spid_pkg::ACT_SQ:
            begin
                prod_p_reg <= spid_pkg::sat61(66'(pp));
            end
            spid_pkg::ACT_PD:
            begin
                prod_d_reg <= spid_pkg::sat61(66'(pdd));
            end
            spid_pkg::ACT_STEER:
            begin
                steer_hold_reg <= spid_pkg::sat48(steer_sum);
            end
            spid_pkg::ACT_RMS:
            begin
                rms_reg <= rms_next;
            end
            spid_pkg::ACT_DIV_LR:
            begin
                lrz_reg  <= lrz_next;
                lrhi_reg <= lrhi_next;
            end
            spid_pkg::ACT_LR:
            begin
                delta_reg <= $signed({1'b0, prev_reg}) - $signed({1'b0, rms_reg});
            end
            spid_pkg::ACT_PUBLISH:
            begin
                steer_reg <= steer_hold_reg;
                still_reg <= train_reg;
            end
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.mul_done  = mul_done;
        stat.dsq_done  = dsq_done;
        stat.epoch_hit = epoch_hit_reg;
        stat.training  = train_reg;
        stat.out_free  = !valid_reg || result_ready;
    end

    assign result_valid   = valid_reg;
    assign steer          = steer_reg;
    assign still_training = still_reg;

endmodule

/* sv/spid_ctrl.sv */
// controller state machine sequencing the datapath for one item and the epoch-end tuning
// depends on spid_pkg

module spid_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  spid_pkg::dp_stat_t    stat,
    output spid_pkg::dp_cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_PD    = 4'd2;
    localparam logic [3:0] ST_MI    = 4'd3;
    localparam logic [3:0] ST_MIW   = 4'd4;
    localparam logic [3:0] ST_DIV1  = 4'd5;
    localparam logic [3:0] ST_DIV1W = 4'd6;
    localparam logic [3:0] ST_SQW   = 4'd7;
    localparam logic [3:0] ST_LRMW  = 4'd8;
    localparam logic [3:0] ST_LRDW  = 4'd9;
    localparam logic [3:0] ST_TCHK  = 4'd10;
    localparam logic [3:0] ST_T1W   = 4'd11;
    localparam logic [3:0] ST_T2W   = 4'd12;
    localparam logic [3:0] ST_T3W   = 4'd13;
    localparam logic [3:0] ST_CLR   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] g_reg, g_next;

    always_comb
    begin
        state_next = state_reg;
        g_next     = g_reg;
        cmd.act    = spid_pkg::ACT_NONE;
        cmd.gsel   = g_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.act    = spid_pkg::ACT_ACCEPT;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.act    = spid_pkg::ACT_SQ;
                state_next = ST_PD;
            end
            ST_PD:
            begin
                cmd.act    = spid_pkg::ACT_PD;
                state_next = ST_MI;
            end
            ST_MI:
            begin
                cmd.act    = spid_pkg::ACT_MUL_INTEG;
                state_next = ST_MIW;
            end
            ST_MIW:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = spid_pkg::ACT_STEER;
                    state_next = (stat.epoch_hit && stat.training) ? ST_DIV1 : ST_OUT;
                end
            end
            ST_DIV1:
            begin
                cmd.act    = spid_pkg::ACT_DIV_MS;
                state_next = ST_DIV1W;
            end
            ST_DIV1W:
            begin
                if (stat.dsq_done)
                begin
                    cmd.act    = spid_pkg::ACT_SQRT;
                    state_next = ST_SQW;
                end
            end
            ST_SQW:
            begin
                if (stat.dsq_done)
                begin
                    cmd.act    = spid_pkg::ACT_RMS;
                    state_next = ST_LRMW;
                end
            end
            ST_LRMW:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = spid_pkg::ACT_DIV_LR;
                    state_next = ST_LRDW;
                end
            end
            ST_LRDW:
            begin
                cmd.act    = spid_pkg::ACT_LR;
                g_next     = spid_pkg::GSEL_KP;
                state_next = ST_TCHK;
            end
            ST_TCHK:
            begin
                if (stat.training)
                begin
                    cmd.act    = spid_pkg::ACT_T1;
                    state_next = ST_T1W;
                end
                else
                begin
                    state_next = ST_CLR;
                end
            end
            ST_T1W:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = spid_pkg::ACT_T2;
                    state_next = ST_T2W;
                end
            end
            ST_T2W:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = spid_pkg::ACT_T3;
                    state_next = ST_T3W;
                end
            end
            ST_T3W:
            begin
                if (stat.mul_done)
                begin
                    cmd.act = spid_pkg::ACT_GAIN;
                    if (g_reg == spid_pkg::GSEL_KD)
                    begin
                        state_next = ST_CLR;
                    end
                    else
                    begin
                        g_next     = g_reg + 1'b1;
                        state_next = ST_TCHK;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.act    = spid_pkg::ACT_CLEAR;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = spid_pkg::ACT_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            g_reg     <= spid_pkg::GSEL_KP;
        end
        else
        begin
            state_reg <= state_next;
            g_reg     <= g_next;
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);

endmodule

/* sv/spid_checker.sv */
// port-level checks for the self-tuning pid controller, bound to the top level
// depends on self_tuning_pid_controller

module spid_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    input  logic         sample_ready,
    input  logic         result_valid,
    input  logic         result_ready,
    input  logic [47:0]  steer,
    input  logic         still_training
);

    logic [1:0] pending_reg;
    logic       off_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            off_seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, sample_valid && sample_ready}
                                       - {1'b0, result_valid && result_ready};
            if (result_valid && result_ready && !still_training)
                off_seen_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(steer)
                                          && $stable(still_training))
        else $error("result changed while stalled");

    // no result without an accepted sample
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without sample");

    // one sample in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while busy");

    // tuning never restarts without reset
    a_tuning_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && off_seen_reg |-> !still_training)
        else $error("tuning restarted");

endmodule

bind self_tuning_pid_controller spid_checker u_spid_checker (.*);
